FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, always checked.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/uts_pkg.sv
// ----------------------------------------------------------------------------
// uts_pkg
// Types and constants of the UART transmit serializer with byte queue.
// ----------------------------------------------------------------------------
package uts_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned RQ_DEPTH        = 2;

  localparam logic [15:0] BIT_PERIOD_RST = 16'd104;
  localparam logic [3:0]  FRAME_LEN      = 4'd10;
  localparam logic [3:0]  START_IDX      = 4'd0;
  localparam logic [3:0]  STOP_IDX       = 4'd9;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } uts_in_t;

  typedef struct packed {
    logic line_level;
    logic idle;
    logic dropped;
  } uts_out_t;

  typedef struct packed {
    logic nonempty;
    logic empty_nxt;
  } uts_q_status_t;

endpackage

FILE: rtl/uts_ram.sv
// ----------------------------------------------------------------------------
// uts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/uts_front.sv
// ----------------------------------------------------------------------------
// uts_front
// Byte queue: takes pushed bytes, flags drops when full, hands bytes to the
// serializer on request.
// ----------------------------------------------------------------------------
module uts_front #(
  parameter int unsigned QUEUE_DEPTH = uts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_en,
  input  logic [7:0]            push_byte,
  input  logic                  pop_en,
  output logic                  dropped,
  output uts_pkg::uts_q_status_t status,
  output logic [7:0]            pop_byte
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          full;
  logic          wr_ok;

  assign full  = (count_r == CNT_FULL);
  assign wr_ok = push_en && !full;

  assign dropped = push_en && full;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (wr_ok) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + PW'(1);
      count_nxt = count_r + CW'(1);
    end else if (pop_en) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + PW'(1);
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign status.nonempty  = (count_r != '0);
  assign status.empty_nxt = (count_nxt == '0);

  uts_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(tail_r),
    .wdata(push_byte),
    .re   (pop_en),
    .raddr(head_r),
    .rdata(pop_byte)
  );

endmodule

FILE: rtl/uts_serializer.sv
// ----------------------------------------------------------------------------
// uts_serializer
// 8N1 frame engine: starts a frame from the byte queue, drives the line
// level and runs the bit timer.
// ----------------------------------------------------------------------------
module uts_serializer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tick_en,
  input  logic [15:0]            bit_period,
  input  uts_pkg::uts_q_status_t q_status,
  input  logic [7:0]             q_byte,
  output logic                   pop_en,
  output logic                   line_level,
  output logic                   sending_nxt
);

  logic        sending_r;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  data_r;
  logic        load_r;
  logic [7:0]  data_src;
  logic [3:0]  idx_m1;
  logic        cur_level;
  logic        run;
  logic [16:0] tick_inc;
  logic [3:0]  idx_inc;

  assign pop_en   = tick_en && !sending_r && q_status.nonempty;
  assign data_src = load_r ? q_byte : data_r;
  assign idx_m1   = bit_idx_r - 4'd1;

  always_comb begin
    if (!sending_r) begin
      cur_level = 1'b1;
    end else if (bit_idx_r == uts_pkg::START_IDX) begin
      cur_level = 1'b0;
    end else if (bit_idx_r == uts_pkg::STOP_IDX) begin
      cur_level = 1'b1;
    end else begin
      cur_level = data_src[idx_m1[2:0]];
    end
  end

  // start bit is low, so a frame start drives 0 without the byte
  assign line_level = pop_en ? 1'b0 : cur_level;

  assign run      = tick_en && (sending_r || pop_en);
  assign tick_inc = {1'b0, (pop_en ? 16'd0 : tick_r)} + 17'd1;
  assign idx_inc  = (pop_en ? uts_pkg::START_IDX : bit_idx_r) + 4'd1;

  always_comb begin
    sending_nxt = sending_r;
    tick_nxt    = tick_r;
    bit_idx_nxt = bit_idx_r;
    if (run) begin
      sending_nxt = 1'b1;
      if (tick_inc >= {1'b0, bit_period}) begin
        tick_nxt    = '0;
        bit_idx_nxt = idx_inc;
        if (idx_inc >= uts_pkg::FRAME_LEN) begin
          sending_nxt = 1'b0;
        end
      end else begin
        tick_nxt    = tick_inc[15:0];
        bit_idx_nxt = pop_en ? uts_pkg::START_IDX : bit_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      tick_r    <= '0;
      bit_idx_r <= '0;
      load_r    <= 1'b0;
    end else begin
      sending_r <= sending_nxt;
      tick_r    <= tick_nxt;
      bit_idx_r <= bit_idx_nxt;
      load_r    <= pop_en;
    end
  end

  always_ff @(posedge clk) begin
    if (load_r) begin
      data_r <= q_byte;
    end
  end

endmodule

FILE: rtl/uts_result_q.sv
// ----------------------------------------------------------------------------
// uts_result_q
// Small result queue between the step logic and the output channel.
// ----------------------------------------------------------------------------
module uts_result_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  uts_pkg::uts_out_t wr_data,
  input  logic              rd_en,
  output logic              full,
  output logic              empty,
  output uts_pkg::uts_out_t rd_data
);

  localparam int unsigned PW = $clog2(uts_pkg::RQ_DEPTH);
  localparam int unsigned CW = $clog2(uts_pkg::RQ_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(uts_pkg::RQ_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(uts_pkg::RQ_DEPTH);

  uts_pkg::uts_out_t mem_r [uts_pkg::RQ_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/uart_tx_serializer_queue.sv
// ----------------------------------------------------------------------------
// uart_tx_serializer_queue
// UART 8N1 transmitter with a byte queue in front of the serializer.
// ----------------------------------------------------------------------------
// Input channel (in_push/in_full): each transfer is either a byte push
// (kind 0) or one bit-clock tick (kind 1). Pushed bytes go into a
// QUEUE_DEPTH-entry queue; a push that finds it full is dropped and flagged.
// On a tick with the serializer idle, the oldest byte is framed as start
// bit, eight data bits LSB first, stop bit, each bit held bit_period ticks.
// Result channel (out_empty/out_pop): one result per input transfer with the
// line level, the idle flag and the drop flag, in input order.
// Config channel (cfg_valid/cfg_ready): writes bit_period; always ready.
// Write it only while no result is pending; it applies from the next tick.
// A result is visible in the cycle after its input transfer.
// Throughput: one item per cycle while the result queue has room; the step
// logic never stalls and a two-entry result queue decouples the output side.
// When the receiver stalls, the result queue fills and in_full rises after
// two pending results; no item is lost. Reset empties both queues, stops the
// serializer and loads bit_period with 104.
// ----------------------------------------------------------------------------
module uart_tx_serializer_queue #(
  parameter int unsigned QUEUE_DEPTH = uts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  uts_pkg::uts_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output uts_pkg::uts_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  logic                   accept;
  logic                   push_en;
  logic                   tick_en;
  logic                   pop_en;
  logic                   dropped;
  logic                   line_level;
  logic                   sending_nxt;
  logic [7:0]             q_byte;
  logic [15:0]            bit_period_r;
  uts_pkg::uts_q_status_t q_status;
  uts_pkg::uts_out_t      res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= uts_pkg::BIT_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      bit_period_r <= cfg_data;
    end
  end

  assign accept  = in_push && !in_full;
  assign push_en = accept && (in_data.kind == uts_pkg::KIND_PUSH);
  assign tick_en = accept && (in_data.kind == uts_pkg::KIND_TICK);

  uts_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (push_en),
    .push_byte(in_data.data_byte),
    .pop_en   (pop_en),
    .dropped  (dropped),
    .status   (q_status),
    .pop_byte (q_byte)
  );

  uts_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_en    (tick_en),
    .bit_period (bit_period_r),
    .q_status   (q_status),
    .q_byte     (q_byte),
    .pop_en     (pop_en),
    .line_level (line_level),
    .sending_nxt(sending_nxt)
  );

  assign res.line_level = line_level;
  assign res.idle       = !sending_nxt && q_status.empty_nxt;
  assign res.dropped    = dropped;

  uts_result_q u_resq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_data(res),
    .rd_en  (out_pop && !out_empty),
    .full   (in_full),
    .empty  (out_empty),
    .rd_data(out_data)
  );

endmodule

FILE: rtl/uts_checker.sv
// ----------------------------------------------------------------------------
// uts_checker
// Port-level checks of the UART transmit serializer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uts_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input uts_pkg::uts_out_t out_data
);

  logic in_xfer;
  logic res_vld;

  assign in_xfer = in_push && !in_full;
  assign res_vld = !out_empty;

  `ASSERT_CLKD(a_idle_line_high, clk, rst_n, res_vld && out_data.idle |-> out_data.line_level, "idle with low line")
  `ASSERT_CLKD(a_drop_not_idle, clk, rst_n, res_vld && out_data.dropped |-> !out_data.idle, "drop while idle")
  `ASSERT_CLKD(a_full_has_results, clk, rst_n, in_full |-> res_vld, "full with no result")
  `ASSERT_CLKD(a_xfer_result, clk, rst_n, in_xfer |=> res_vld, "no result after transfer")
  `ASSERT_CLKD(a_out_hold, clk, rst_n, res_vld && !out_pop |=> res_vld && $stable(out_data), "waiting result changed")

endmodule

bind uart_tx_serializer_queue uts_checker u_uts_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_push  (in_push),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_data (out_data)
);
